>>> sv/enlb_pkg.sv
// Shared types, widths and register indexes of the edge-normalized line blur.
package enlb_pkg;

  localparam int MAX_HALF_DEF = 6;
  localparam int PIX_W = 8;
  localparam int WEIGHT_W = 17;
  localparam int TAP_CNT = 7;
  localparam int HALF_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W = PIX_W + WEIGHT_W;
  localparam int ACC_W = 28;
  localparam int WSUM_W = 20;
  localparam int QUOT_W = 8;
  localparam int QBIT_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_TAPS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_CENTER = 3'd1;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             line_end;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             line_done;
  } out_item_t;

  typedef struct packed {
    logic              clear;
    logic              mac;
    logic              div;
    logic [QBIT_W-1:0] div_bit;
  } alu_ctrl_t;

endpackage

>>> sv/enlb_alu.sv
// Shared multiply-accumulate and restoring-divide unit of the line blur.
module enlb_alu
  import enlb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  alu_ctrl_t           ctrl,
  input  logic [WEIGHT_W-1:0] weight,
  input  logic [PIX_W-1:0]    pixel,
  output logic [QUOT_W-1:0]   quotient
);

  logic [PROD_W-1:0]   prod;
  logic [WEIGHT_W-1:0] prod_w;
  logic                prod_en;
  logic [ACC_W-1:0]    acc;
  logic [WSUM_W-1:0]   wsum;
  logic [QUOT_W-1:0]   quot;
  logic [ACC_W-1:0]    dvs;
  logic                fits;

  assign dvs = ACC_W'(wsum) << ctrl.div_bit;
  assign fits = acc >= dvs;
  assign quotient = (wsum == '0) ? '0 : quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_en <= 1'b0;
    end else begin
      prod_en <= ctrl.mac && !ctrl.clear;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mac) begin
      prod <= PROD_W'(weight) * PROD_W'(pixel);
      prod_w <= weight;
    end
    if (ctrl.clear) begin
      acc <= '0;
      wsum <= '0;
      quot <= '0;
    end else if (ctrl.div) begin
      if (fits) begin
        acc <= acc - dvs;
        quot[ctrl.div_bit] <= 1'b1;
      end
    end else if (prod_en) begin
      acc <= acc + ACC_W'(prod);
      wsum <= wsum + WSUM_W'(prod_w);
    end
  end

endmodule

>>> sv/edge_normalized_line_blur.sv
// Top level of the edge-normalized line blur: pixel window, sequencer and configuration.
//
// Each pixel transaction is taken while the sequencer is idle. A pixel that completes an output, and the
// line-end pixel that flushes up to h+1 outputs, hold the input stalled while a single shared
// multiply-accumulate unit walks the whole window of 2*MAX_HALF+1 entries (one entry per cycle),
// drains its product register, and then runs a restoring division over the 8 quotient bits.
// The result stays registered until it is taken, also while the result side stalls.
// Configuration writes are taken at any time and must only be made while no pixel is being
// processed.
module edge_normalized_line_blur
  import enlb_pkg::*;
#(
  parameter int MAX_HALF = MAX_HALF_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pix_valid,
  output logic                 pix_stall,
  input  in_item_t             pix,
  output logic                 res_valid,
  input  logic                 res_stall,
  output out_item_t            res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WEIGHT_W-1:0]  cfg_data
);

  localparam int DEPTH = 2 * MAX_HALF + 1;
  localparam int WIW = $clog2(DEPTH);
  localparam int CW = $clog2(MAX_HALF + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAC = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_DIV = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;

  logic [2:0]          state, state_next;
  logic [CW-1:0]       seen, seen_next;
  logic [CW-1:0]       emitted, emitted_next;
  logic [CW-1:0]       cur_c, cur_c_next;
  logic                flush, flush_next;
  logic [WIW-1:0]      e, e_next;
  logic [QBIT_W-1:0]   div_bit, div_bit_next;
  logic [HALF_W-1:0]   half_taps;
  logic [WEIGHT_W-1:0] tap_weight [TAP_CNT];
  logic [PIX_W-1:0]    window [DEPTH];

  logic                accept_in;
  logic                out_acc;
  logic                finish;
  logic [CW-1:0]       h_eff;
  logic [CW-1:0]       lim;
  logic [WIW-1:0]      reach;
  logic [WIW-1:0]      d;
  logic [CW-1:0]       emitted_inc;
  alu_ctrl_t           ctrl;
  logic [QUOT_W-1:0]   quotient;

  assign pix_stall = state != S_IDLE;
  assign accept_in = pix_valid && (state == S_IDLE);
  assign res_valid = state == S_OUT;
  assign out_acc = res_valid && !res_stall;
  assign finish = !flush || (cur_c == '0);

  assign h_eff = (half_taps > HALF_W'(MAX_HALF)) ? CW'(MAX_HALF) : CW'(half_taps);
  assign lim = (h_eff < emitted) ? h_eff : emitted;
  assign reach = WIW'(cur_c) + WIW'(lim);
  assign d = (e >= WIW'(cur_c)) ? e - WIW'(cur_c) : WIW'(cur_c) - e;
  assign emitted_inc = (emitted < CW'(MAX_HALF)) ? emitted + 1'b1 : emitted;

  assign res.pixel_out = quotient;
  assign res.line_done = flush && (cur_c == '0);

  always_comb begin
    state_next = state;
    seen_next = seen;
    emitted_next = emitted;
    cur_c_next = cur_c;
    flush_next = flush;
    e_next = e;
    div_bit_next = div_bit;
    ctrl = '0;
    ctrl.div_bit = div_bit;
    unique case (state)
      S_IDLE: begin
        if (accept_in) begin
          if (!pix.line_end && (seen < h_eff)) begin
            seen_next = seen + 1'b1;
          end else begin
            state_next = S_MAC;
            e_next = '0;
            ctrl.clear = 1'b1;
            flush_next = pix.line_end;
            if (pix.line_end) begin
              cur_c_next = (seen >= h_eff) ? h_eff : seen;
              seen_next = '0;
            end else begin
              cur_c_next = h_eff;
            end
          end
        end
      end
      S_MAC: begin
        ctrl.mac = e <= reach;
        e_next = e + 1'b1;
        if (e == WIW'(DEPTH - 1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DIV;
        div_bit_next = QBIT_W'(QUOT_W - 1);
      end
      S_DIV: begin
        ctrl.div = 1'b1;
        div_bit_next = div_bit - 1'b1;
        if (div_bit == '0) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          if (finish) begin
            state_next = S_IDLE;
            emitted_next = flush ? '0 : emitted_inc;
          end else begin
            state_next = S_MAC;
            emitted_next = emitted_inc;
            cur_c_next = cur_c - 1'b1;
            e_next = '0;
            ctrl.clear = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      seen <= '0;
      emitted <= '0;
      cur_c <= '0;
      flush <= 1'b0;
      e <= '0;
      div_bit <= '0;
    end else begin
      state <= state_next;
      seen <= seen_next;
      emitted <= emitted_next;
      cur_c <= cur_c_next;
      flush <= flush_next;
      e <= e_next;
      div_bit <= div_bit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_taps <= HALF_W'(1);
      for (int i = 0; i < TAP_CNT; i++) begin
        tap_weight[i] <= '0;
      end
      tap_weight[0] <= WEIGHT_W'(2);
      tap_weight[1] <= WEIGHT_W'(1);
    end else if (cfg_we) begin
      if (cfg_index == REG_HALF_TAPS) begin
        half_taps <= cfg_data[HALF_W-1:0];
      end else begin
        tap_weight[3'(cfg_index - REG_WEIGHT_CENTER)] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      window[0] <= pix.pixel_in;
      for (int i = 1; i < DEPTH; i++) begin
        window[i] <= window[i-1];
      end
    end
  end

  enlb_alu u_alu (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .weight   (tap_weight[3'(d)]),
    .pixel    (window[e]),
    .quotient (quotient)
  );

  a_input_then_busy: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && !pix_stall) |=> !res_valid)
    else $error("A result appeared in the cycle after an input transaction.");

  a_done_frees_input: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_stall && res.line_done) |=> !pix_stall)
    else $error("Input still stalled after the last result of a line.");

  a_emitted_bound: assert property (@(posedge clk) disable iff (rst)
    (emitted <= CW'(MAX_HALF)) && (cur_c <= CW'(MAX_HALF)))
    else $error("Output count or center index beyond the kernel half width.");

endmodule

>>> test/edge_normalized_line_blur_test.sv
// Self-checking testbench for the edge-normalized line blur, with its own line blur predictor.
module edge_normalized_line_blur_test
  import enlb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_DEPTH = 2 * MAX_HALF_DEF + 1;
  localparam int SETTLE_CYCLES = 2 * MAX_HALF_DEF + 31;
  localparam int CYCLE_LIMIT = 500000;

  class blur_checker;
    logic [HALF_W-1:0]   half_reg;
    logic [WEIGHT_W-1:0] weight [TAP_CNT];
    logic [PIX_W-1:0]    window [WIN_DEPTH];
    int unsigned         seen;
    int unsigned         emitted;
    out_item_t           expected_pixels [$];
    int unsigned         errors;
    int unsigned         pixels_taken;
    int unsigned         lines_taken;
    int unsigned         results_checked;
    logic [7:0]          halves_used;

    function new();
      half_reg = 3'd1;
      foreach (weight[i]) weight[i] = '0;
      weight[0] = 17'd2;
      weight[1] = 17'd1;
      foreach (window[i]) window[i] = '0;
      seen = 0;
      emitted = 0;
      errors = 0;
      pixels_taken = 0;
      lines_taken = 0;
      results_checked = 0;
      halves_used = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WEIGHT_W-1:0] val);
      if (idx == REG_HALF_TAPS) begin
        half_reg = val[HALF_W-1:0];
      end else begin
        weight[idx - REG_WEIGHT_CENTER] = val;
      end
    endfunction

    // Mean around window entry c, using only the taps that lie inside the current line.
    function logic [PIX_W-1:0] weighted_mean(int unsigned c, int unsigned right_n,
                                             int unsigned left_n, int unsigned h);
      longint unsigned acc;
      longint unsigned wsum;
      longint unsigned q;
      int unsigned d;
      acc = longint'(weight[0]) * longint'(window[c]);
      wsum = longint'(weight[0]);
      for (d = 1; d <= h; d++) begin
        if (d <= right_n && d <= c) begin
          acc += longint'(weight[d]) * longint'(window[c - d]);
          wsum += longint'(weight[d]);
        end
        if (d <= left_n && c + d < WIN_DEPTH) begin
          acc += longint'(weight[d]) * longint'(window[c + d]);
          wsum += longint'(weight[d]);
        end
      end
      if (wsum == 0) begin
        return '0;
      end
      q = acc / wsum;
      return q[PIX_W-1:0];
    endfunction

    function void add_expected(logic [PIX_W-1:0] p, logic done);
      out_item_t e;
      e.pixel_out = p;
      e.line_done = done;
      expected_pixels.push_back(e);
      if (emitted < MAX_HALF_DEF) begin
        emitted++;
      end
    endfunction

    function void take_pixel(in_item_t it);
      int unsigned h;
      int unsigned m;
      int unsigned c;
      int unsigned j;
      int i;
      h = (half_reg > MAX_HALF_DEF) ? MAX_HALF_DEF : half_reg;
      halves_used[half_reg] = 1'b1;
      pixels_taken++;
      for (i = WIN_DEPTH - 1; i > 0; i--) begin
        window[i] = window[i - 1];
      end
      window[0] = it.pixel_in;
      if (!it.line_end) begin
        if (seen < h) begin
          seen++;
        end else begin
          add_expected(weighted_mean(h, h, emitted, h), 1'b0);
        end
      end else begin
        lines_taken++;
        m = (seen >= h) ? h + 1 : seen + 1;
        for (j = 0; j < m; j++) begin
          c = m - 1 - j;
          add_expected(weighted_mean(c, c, emitted, h), (j + 1 == m));
        end
        seen = 0;
        emitted = 0;
      end
    endfunction

    function void check_pixel(out_item_t got);
      out_item_t want;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result transaction: expected none, got pixel_out=%0d line_done=%0b",
                 $time, got.pixel_out, got.line_done);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      results_checked++;
      if (got.pixel_out !== want.pixel_out) begin
        $display("%0t: pixel_out mismatch: expected %0d, got %0d",
                 $time, want.pixel_out, got.pixel_out);
        errors++;
      end
      if (got.line_done !== want.line_done) begin
        $display("%0t: line_done mismatch: expected %0b, got %0b",
                 $time, want.line_done, got.line_done);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 pix_valid;
  logic                 pix_stall;
  in_item_t             pix;
  logic                 res_valid;
  logic                 res_stall;
  out_item_t            res;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WEIGHT_W-1:0]  cfg_data;

  blur_checker          sb;
  int unsigned          send_idle_pct;
  int unsigned          recv_stall_pct;
  int unsigned          cycle_count;
  logic [WEIGHT_W-1:0]  next_weight [TAP_CNT];

  edge_normalized_line_blur u_top (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) begin
        sb.write_reg(cfg_index, cfg_data);
      end
      if (pix_valid && !pix_stall) begin
        sb.take_pixel(pix);
      end
      if (res_valid && !res_stall) begin
        sb.check_pixel(res);
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Each task below is entered and left at a falling edge.
  task automatic send_pixel(logic [PIX_W-1:0] p, logic e);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pix_valid <= 1'b0;
      @(negedge clk);
    end
    pix_valid <= 1'b1;
    pix.pixel_in <= p;
    pix.line_end <= e;
    do begin
      @(posedge clk);
    end while (pix_stall);
    @(negedge clk);
  endtask

  task automatic drain_results();
    pix_valid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic wait_idle();
    pix_valid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_config(logic [HALF_W-1:0] h);
    int d;
    cfg_we <= 1'b1;
    cfg_index <= REG_HALF_TAPS;
    cfg_data <= WEIGHT_W'(h);
    @(negedge clk);
    for (d = 0; d < TAP_CNT; d++) begin
      cfg_index <= CFG_IDX_W'(REG_WEIGHT_CENTER + d);
      cfg_data <= next_weight[d];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return WEIGHT_W'(65536);
      2: return WEIGHT_W'($urandom_range(0, 65536));
      default: return WEIGHT_W'($urandom_range(0, 16));
    endcase
  endfunction

  task automatic random_config();
    int d;
    logic all_zero;
    all_zero = ($urandom_range(0, 7) == 0);
    for (d = 0; d < TAP_CNT; d++) begin
      next_weight[d] = all_zero ? '0 : pick_weight();
    end
    load_config(HALF_W'($urandom_range(0, 7)));
  endtask

  task automatic set_weights(int w0, int w1, int w2, int w3, int rest);
    int d;
    next_weight[0] = WEIGHT_W'(w0);
    next_weight[1] = WEIGHT_W'(w1);
    next_weight[2] = WEIGHT_W'(w2);
    next_weight[3] = WEIGHT_W'(w3);
    for (d = 4; d < TAP_CNT; d++) begin
      next_weight[d] = WEIGHT_W'(rest);
    end
  endtask

  initial begin
    int stage;
    int phase;
    int items;
    int len;
    int k;
    int pause_at;
    logic forced_pause;

    sb = new();
    rst = 1'b1;
    pix_valid = 1'b0;
    pix = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 36;
    recv_stall_pct = 86;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Lines of one, two and three pixels with the kernel present after reset.
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b1);

    // Widest kernel with every weight at 65536, on a line shorter than the kernel.
    wait_idle();
    set_weights(65536, 65536, 65536, 65536, 65536);
    load_config(3'd6);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd128, 1'b0);
    send_pixel(8'd1, 1'b1);

    // A half width above the maximum, with every weight zero.
    wait_idle();
    set_weights(0, 0, 0, 0, 0);
    load_config(3'd7);
    send_pixel(8'd200, 1'b0);
    send_pixel(8'd100, 1'b1);

    // No neighbors and a zero center weight.
    wait_idle();
    set_weights(0, 65536, 65536, 65536, 65536);
    load_config(3'd0);
    send_pixel(8'd7, 1'b0);
    send_pixel(8'd9, 1'b1);

    // Zero center weight with live neighbors.
    wait_idle();
    set_weights(0, 3, 0, 0, 0);
    load_config(3'd1);
    send_pixel(8'd10, 1'b0);
    send_pixel(8'd20, 1'b0);
    send_pixel(8'd30, 1'b1);

    // The kernel changes in the middle of a line.
    wait_idle();
    set_weights(1, 1, 1, 0, 0);
    load_config(3'd2);
    send_pixel(8'd50, 1'b0);
    send_pixel(8'd60, 1'b0);
    send_pixel(8'd70, 1'b0);
    wait_idle();
    set_weights(4, 2, 1, 5, 0);
    load_config(3'd3);
    send_pixel(8'd80, 1'b0);
    send_pixel(8'd90, 1'b1);

    forced_pause = 1'b1;
    for (stage = 0; stage < 3; stage++) begin
      case (stage)
        0: begin
          send_idle_pct = 36;
          recv_stall_pct = 86;
        end
        1: begin
          send_idle_pct = 86;
          recv_stall_pct = 36;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (phase = 0; phase < 4; phase++) begin
        wait_idle();
        random_config();
        items = 0;
        while (items < 15) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 40) : $urandom_range(1, 12);
          pause_at = (forced_pause || $urandom_range(0, 5) == 0) ? $urandom_range(0, len - 1) : -1;
          forced_pause = 1'b0;
          for (k = 0; k < len; k++) begin
            if (k == pause_at) begin
              drain_results();
            end
            send_pixel(PIX_W'($urandom_range(0, 255)), (k == len - 1));
          end
          items += len;
        end
      end
    end

    wait_idle();
    $display("Ran %0d pixel transactions over %0d lines and checked %0d blurred results.",
             sb.pixels_taken, sb.lines_taken, sb.results_checked);
    $display("Half width settings exercised (bit per value 0..7): %b.", sb.halves_used);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
